// ===== sv/fhrw_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types and constants for the file header record walker.
package fhrw_pkg;

   localparam logic [2:0] STATUS_FOUND      = 3'd0;
   localparam logic [2:0] STATUS_BAD_TYPE   = 3'd1;
   localparam logic [2:0] STATUS_BAD_LENGTH = 3'd2;
   localparam logic [2:0] STATUS_ZERO_LEN   = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd4;

   localparam logic [7:0]  PRIMARY_TYPE   = 8'd0;
   localparam logic [15:0] PRIMARY_LENGTH = 16'd16;
   localparam logic [31:0] TOTAL_LEN_OFFSET = 32'd4;

   localparam int QUEUE_DEPTH = 3;

   typedef enum logic [1:0] {
      PHASE_WALKING = 2'd0,
      PHASE_DONE    = 2'd1
   } phase_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  header_type;
      logic [31:0] header_offset;
      logic        last_result;
   } result_type;

   // results raised by one accepted item, in order
   typedef struct packed {
      logic [1:0] count;
      result_type item0;
      result_type item1;
   } push_type;

endpackage

// ===== sv/fhrw_walker.sv =====
`timescale 1ns / 1ps
// Walk state registers and per-byte decode of the header record chain.
module fhrw_walker (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output fhrw_pkg::push_type push
);
   import fhrw_pkg::*;

   logic [31:0] byte_count_ff,          byte_count_in;
   logic [32:0] next_record_at_ff,      next_record_at_in;
   logic [31:0] header_area_length_ff,  header_area_length_in;
   logic [7:0]  pending_type_ff,        pending_type_in;
   logic [7:0]  pending_length_high_ff, pending_length_high_in;
   phase_type   phase_ff,               phase_in;

   logic        walking;
   logic        at_zero, at_one, at_two, at_total, at_seven, past_primary;
   logic [31:0] total_shift;
   logic [15:0] rec_len;
   logic [33:0] rel;
   logic        at_rec_type, at_rec_high, at_rec_low;
   logic [32:0] next_pos;
   logic        next_end, primary_end, done_now, truncated;
   logic        has_first;
   result_type  first, trunc_rec;

   assign walking      = (phase_ff == PHASE_WALKING);
   assign at_zero      = (byte_count_ff == 32'd0);
   assign at_one       = (byte_count_ff == 32'd1);
   assign at_two       = (byte_count_ff == 32'd2);
   assign at_total     = (byte_count_ff >= 32'd4) && (byte_count_ff <= 32'd7);
   assign at_seven     = (byte_count_ff == 32'd7);
   assign past_primary = (byte_count_ff >= 32'd8);
   assign total_shift  = {header_area_length_ff[23:0], data_byte};
   assign rec_len      = {pending_length_high_ff, data_byte};
   assign rel          = {2'b00, byte_count_ff} - {1'b0, next_record_at_ff};
   assign at_rec_type  = past_primary && (rel == 34'd0);
   assign at_rec_high  = past_primary && (rel == 34'd1);
   assign at_rec_low   = past_primary && (rel == 34'd2);
   assign next_pos     = next_record_at_ff + {17'd0, rec_len};
   assign next_end     = (next_pos >= {1'b0, header_area_length_ff});
   assign primary_end  = (next_record_at_ff >= {1'b0, total_shift});

   assign done_now = walking && (
        (at_zero && (data_byte != PRIMARY_TYPE))
     || (at_two && (rec_len != PRIMARY_LENGTH))
     || (at_seven && ((total_shift == 32'd0) || primary_end))
     || (at_rec_low && ((rec_len == 16'd0) || next_end)));
   assign truncated = last_byte && walking && !done_now;

   // next state
   always_comb begin
      byte_count_in          = byte_count_ff;
      next_record_at_in      = next_record_at_ff;
      header_area_length_in  = header_area_length_ff;
      pending_type_in        = pending_type_ff;
      pending_length_high_in = pending_length_high_ff;
      phase_in               = done_now ? PHASE_DONE : phase_ff;
      if (walking) begin
         priority if (at_zero) begin
            pending_type_in = data_byte;
         end else if (at_one) begin
            pending_length_high_in = data_byte;
         end else if (at_two) begin
            if (rec_len == PRIMARY_LENGTH) begin
               next_record_at_in = {17'd0, rec_len};
            end
         end else if (at_total) begin
            header_area_length_in = total_shift;
         end else if (at_rec_type) begin
            pending_type_in = data_byte;
         end else if (at_rec_high) begin
            pending_length_high_in = data_byte;
         end else if (at_rec_low && (rec_len != 16'd0) && !next_end) begin
            // short records reuse bytes already seen
            if (rec_len == 16'd1) begin
               pending_type_in        = pending_length_high_ff;
               pending_length_high_in = data_byte;
            end else if (rec_len == 16'd2) begin
               pending_type_in = data_byte;
            end
            next_record_at_in = next_pos;
         end else begin
            // no field at this offset
         end
      end
      if (last_byte) begin
         byte_count_in          = 32'd0;
         next_record_at_in      = 33'd0;
         header_area_length_in  = 32'd0;
         pending_type_in        = 8'd0;
         pending_length_high_in = 8'd0;
         phase_in               = PHASE_WALKING;
      end else if (byte_count_ff != 32'hFFFF_FFFF) begin
         byte_count_in = byte_count_ff + 32'd1;
      end
   end

   // results
   always_comb begin
      has_first = 1'b0;
      first     = '0;
      if (walking) begin
         priority if (at_zero && (data_byte != PRIMARY_TYPE)) begin
            has_first = 1'b1;
            first     = '{STATUS_BAD_TYPE, data_byte, 32'd0, 1'b1};
         end else if (at_two && (rec_len != PRIMARY_LENGTH)) begin
            has_first = 1'b1;
            first     = '{STATUS_BAD_LENGTH, 8'd0, 32'd0, 1'b1};
         end else if (at_seven) begin
            has_first = 1'b1;
            if (total_shift == 32'd0) begin
               first = '{STATUS_ZERO_LEN, 8'd0, TOTAL_LEN_OFFSET, 1'b1};
            end else begin
               first = '{STATUS_FOUND, PRIMARY_TYPE, 32'd0, primary_end};
            end
         end else if (at_rec_low) begin
            has_first = 1'b1;
            if (rec_len == 16'd0) begin
               first = '{STATUS_ZERO_LEN, pending_type_ff,
                         next_record_at_ff[31:0], 1'b1};
            end else begin
               first = '{STATUS_FOUND, pending_type_ff,
                         next_record_at_ff[31:0], next_end};
            end
         end else begin
            // no result from this byte
         end
      end
      trunc_rec = '{STATUS_TRUNCATED, 8'd0, byte_count_ff, 1'b1};
      push = '0;
      if (has_first) begin
         push.item0 = first;
         push.item1 = trunc_rec;
         push.count = truncated ? 2'd2 : 2'd1;
      end else begin
         push.item0 = trunc_rec;
         push.item1 = trunc_rec;
         push.count = truncated ? 2'd1 : 2'd0;
      end
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff          <= 32'd0;
         next_record_at_ff      <= 33'd0;
         header_area_length_ff  <= 32'd0;
         pending_type_ff        <= 8'd0;
         pending_length_high_ff <= 8'd0;
         phase_ff               <= PHASE_WALKING;
      end else if (accept) begin
         byte_count_ff          <= byte_count_in;
         next_record_at_ff      <= next_record_at_in;
         header_area_length_ff  <= header_area_length_in;
         pending_type_ff        <= pending_type_in;
         pending_length_high_ff <= pending_length_high_in;
         phase_ff               <= phase_in;
      end
   end

endmodule

// ===== sv/fhrw_queue.sv =====
`timescale 1ns / 1ps
// Three-entry result queue taking up to two items a cycle and giving one while out_stall is low.
module fhrw_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  fhrw_pkg::push_type   push,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output fhrw_pkg::result_type out_item
);
   import fhrw_pkg::*;

   result_type entry_ff [QUEUE_DEPTH];
   result_type entry_in [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic [1:0] base;

   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[0];
   assign full      = (count_ff > 2'd1);
   assign pop       = out_valid && !out_stall;
   assign base      = count_ff - {1'b0, pop};
   assign count_in  = base + push.count;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i < QUEUE_DEPTH - 1)) begin
            entry_in[i] = entry_ff[i + 1];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         if ((push.count != 2'd0) && (2'(i) == base)) begin
            entry_in[i] = push.item0;
         end
         if ((push.count == 2'd2) && (2'(i) == base + 2'd1)) begin
            entry_in[i] = push.item1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

// ===== sv/file_header_record_walker.sv =====
`timescale 1ns / 1ps
// Top level: byte-serial walker over the header record chain of a file.
// A result is queued as its byte is accepted and offered after older results.
// Throughput: one byte per cycle while req_stall is low; req_stall rises
// while two or more results wait in the three-entry result queue, so a byte
// raising two results can hold off the next byte until rsp drains one item.
// Reset clears the walk state and empties the queue; the next byte is offset 0.
module file_header_record_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_header_type,
   output logic [31:0] rsp_header_offset,
   output logic        rsp_last_result
);
   import fhrw_pkg::*;

   logic       accept;
   logic       full;
   push_type   push;
   result_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   fhrw_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (push)
   );

   fhrw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (head)
   );

   assign rsp_status        = head.status;
   assign rsp_header_type   = head.header_type;
   assign rsp_header_offset = head.header_offset;
   assign rsp_last_result   = head.last_result;

endmodule

// ===== verif/file_header_record_walker_tb.sv =====
`timescale 1ns / 1ps
// Testbench: file header record walker, byte streams checked against a local walk predictor.
module file_header_record_walker_tb;
   import fhrw_pkg::*;

   typedef logic [7:0] byte_list [$];

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   localparam int ITEM_TARGET = 750;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_header_type;
   logic [31:0] rsp_header_offset;
   logic        rsp_last_result;

   file_header_record_walker DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_header_type   (rsp_header_type),
      .rsp_header_offset (rsp_header_offset),
      .rsp_last_result   (rsp_last_result)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // walk predictor state
   logic [31:0] offset_now = '0;
   logic [32:0] record_start = '0;
   logic [31:0] total_len = '0;
   logic [7:0]  held_type = '0;
   logic [7:0]  held_len_hi = '0;
   phase_type   phase = PHASE_WALKING;

   result_type expected_records [$];
   int errors = 0;
   int bytes_sent = 0;
   int burst_left = 0;

   function automatic void clear_walk();
      offset_now   = '0;
      record_start = '0;
      total_len    = '0;
      held_type    = '0;
      held_len_hi  = '0;
      phase        = PHASE_WALKING;
   endfunction

   function automatic void expect_record(logic [2:0] st, logic [7:0] ty, logic [31:0] off,
                                         logic lr);
      result_type r;
      r.status        = st;
      r.header_type   = ty;
      r.header_offset = off;
      r.last_result   = lr;
      expected_records.push_back(r);
   endfunction

   function automatic void walk_byte(logic [7:0] b, logic fin);
      logic [31:0] c;
      logic [33:0] p;
      logic [33:0] np;
      logic [15:0] len;
      logic        ended;
      c = offset_now;
      if (phase == PHASE_WALKING) begin
         if (c == 0) begin
            held_type = b;
            if (b != PRIMARY_TYPE) begin
               expect_record(STATUS_BAD_TYPE, b, 32'd0, 1'b1);
               phase = PHASE_DONE;
            end
         end else if (c == 1) begin
            held_len_hi = b;
         end else if (c == 2) begin
            len = {held_len_hi, b};
            if (len != PRIMARY_LENGTH) begin
               expect_record(STATUS_BAD_LENGTH, 8'd0, 32'd0, 1'b1);
               phase = PHASE_DONE;
            end else begin
               record_start = 33'(len);
            end
         end else if (c >= 4 && c <= 7) begin
            total_len = {total_len[23:0], b};
            if (c == 7) begin
               if (total_len == 0) begin
                  expect_record(STATUS_ZERO_LEN, 8'd0, TOTAL_LEN_OFFSET, 1'b1);
                  phase = PHASE_DONE;
               end else begin
                  ended = 34'(record_start) >= 34'(total_len);
                  expect_record(STATUS_FOUND, PRIMARY_TYPE, 32'd0, ended);
                  if (ended) phase = PHASE_DONE;
               end
            end
         end else if (c >= 8) begin
            p = 34'(record_start);
            if (34'(c) == p) begin
               held_type = b;
            end else if (34'(c) == p + 34'd1) begin
               held_len_hi = b;
            end else if (34'(c) == p + 34'd2) begin
               len = {held_len_hi, b};
               if (len == 0) begin
                  expect_record(STATUS_ZERO_LEN, held_type, p[31:0], 1'b1);
                  phase = PHASE_DONE;
               end else begin
                  np = p + 34'(len);
                  ended = np >= 34'(total_len);
                  expect_record(STATUS_FOUND, held_type, p[31:0], ended);
                  if (ended) begin
                     phase = PHASE_DONE;
                  end else begin
                     // short records reuse bytes already seen
                     if (len == 16'd1) begin
                        held_type   = held_len_hi;
                        held_len_hi = b;
                     end else if (len == 16'd2) begin
                        held_type = b;
                     end
                     record_start = np[32:0];
                  end
               end
            end
         end
      end
      if (fin) begin
         if (phase == PHASE_WALKING) expect_record(STATUS_TRUNCATED, 8'd0, c, 1'b1);
         clear_walk();
      end else if (offset_now != 32'hFFFF_FFFF) begin
         offset_now = offset_now + 32'd1;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         for (int i = 0; i < gap; i++) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      walk_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_file(input byte_list bytes);
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   task automatic test_bad_primary_type();
      send_file('{8'hFF});
   endtask

   task automatic test_bad_primary_length();
      send_file('{8'h00, 8'h80, 8'h10});
   endtask

   task automatic test_zero_total_length();
      send_file('{8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
   endtask

   // primary found and truncation on the same item
   task automatic test_truncated_file();
      send_file('{8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40});
   endtask

   // short record, then a zero length record made of reused bytes
   task automatic test_record_chain();
      send_file('{8'h00, 8'h00, 8'h10, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h20,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hAA, 8'h00, 8'h02, 8'h00, 8'h00, 8'h5A});
   endtask

   task automatic test_random_files();
      byte_list bytes;
      int kind;
      int nrec;
      int len;
      int area;
      logic [31:0] total;
      while (bytes_sent < ITEM_TARGET) begin
         bytes = {};
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom));
         end else if (kind < 16) begin
            if ($urandom_range(0, 1) == 0) begin
               bytes.push_back(8'($urandom_range(1, 255)));
            end else begin
               bytes.push_back(8'h00);
               bytes.push_back(8'($urandom));
               bytes.push_back(8'($urandom_range(0, 255)) ^ 8'h10 | 8'h01);
            end
            repeat ($urandom_range(0, 6)) bytes.push_back(8'($urandom));
         end else begin
            bytes = '{8'h00, 8'h00, 8'h10, 8'($urandom)};
            repeat (4) bytes.push_back(8'h00);
            repeat (8) bytes.push_back(8'($urandom));
            area = 16;
            nrec = $urandom_range(0, 5);
            for (int r = 0; r < nrec; r++) begin
               kind = $urandom_range(0, 99);
               if (kind < 10)      len = $urandom_range(1, 2);
               else if (kind < 15) len = 0;
               else if (kind < 18) len = $urandom_range(0, 65535);
               else                len = $urandom_range(3, 10);
               bytes.push_back(8'($urandom));
               bytes.push_back(8'(len >> 8));
               bytes.push_back(8'(len));
               for (int k = 3; k < len && k < 40; k++) bytes.push_back(8'($urandom));
               area += len;
            end
            kind = $urandom_range(0, 99);
            if (kind < 5)       total = 32'h0;
            else if (kind < 12) total = $urandom;
            else if (kind < 25) total = 32'(area - $urandom_range(0, 4));
            else                total = 32'(area);
            for (int k = 0; k < 4; k++) bytes[4 + k] = total[31 - 8 * k -: 8];
            repeat ($urandom_range(0, 4)) bytes.push_back(8'($urandom));
            if ($urandom_range(0, 6) == 0)
               bytes = bytes[0 : $urandom_range(0, bytes.size() - 1)];
         end
         send_file(bytes);
      end
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_records.size() == 0) begin
            $error("unexpected result: status %0d type %0h offset %0h last %0b",
                   rsp_status, rsp_header_type, rsp_header_offset, rsp_last_result);
            errors++;
         end else begin
            want = expected_records.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_header_type !== want.header_type) begin
               $error("header_type: expected %0h, got %0h", want.header_type,
                      rsp_header_type);
               errors++;
            end
            if (rsp_header_offset !== want.header_offset) begin
               $error("header_offset: expected %0h, got %0h", want.header_offset,
                      rsp_header_offset);
               errors++;
            end
            if (rsp_last_result !== want.last_result) begin
               $error("last_result: expected %0b, got %0b", want.last_result,
                      rsp_last_result);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin : drive_rsp_stall
      static stall_mode_type mode = STALL_NONE;
      static int left = 0;
      if (left == 0) begin
         mode = stall_mode_type'($urandom_range(0, 3));
         left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 1) == 0);
         STALL_PERIODIC: rsp_stall <= (left % 4 == 0);
         default:        rsp_stall <= 1'b0;
      endcase
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin : watchdog
      static int quiet = 0;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      clear_walk();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bad_primary_type();
      test_bad_primary_length();
      test_zero_total_length();
      test_truncated_file();
      test_record_chain();
      test_random_files();
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_records.size() != 0) begin
         $error("%0d results never arrived", expected_records.size());
         errors++;
      end
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fhrw_pkg.sv
sv/fhrw_walker.sv
sv/fhrw_queue.sv
sv/file_header_record_walker.sv
verif/file_header_record_walker_tb.sv
